### design/jacobi_poisson_grid_solver_macros.svh
// Assertion helpers for the solver module.
`ifndef JACOBI_POISSON_GRID_SOLVER_MACROS_SVH
`define JACOBI_POISSON_GRID_SOLVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JPGS_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("jpgs assertion failed");

// Next-cycle implication, disabled during reset.
`define JPGS_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("jpgs assertion failed");

`endif

### design/jpgs_pkg.sv
package jpgs_pkg;

	localparam int DATA_W = 32;
	localparam int ITER_W = 16;
	localparam int SIZE_W = 7;
	localparam int CMD_W = 2;
	localparam int COORD_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	// Five Q16.16 terms summed exactly.
	localparam int SUM_W = 35;

	localparam logic [ITER_W-1:0] ITER_RESET = 16'd2000;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd50;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ITER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic load;
		logic add;
	} stn_ctrl_t;

endpackage

### design/jacobi_poisson_grid_solver.sv
// Jacobi relaxation solver for the Poisson equation on a square grid.
// Input channel (in_valid/in_ready) carries commands: write cell, solve, read.
// A write transfer stores a cell's potential and source and gives no result.
// A read transfer returns that cell's potential on the output channel
// (out_valid/out_ready) with kind 0.
// A solve transfer runs iteration_count sweeps over the interior of the
// active square, then returns a result with kind 1 and potential zero.
// Each sweep steps every interior cell through phases N, S, W, E and LAST
// (four neighbor reads through the single read port of the potential RAM),
// then copies the new values back for every interior cell in a second pass.
// Writes are taken one per cycle while idle; a read holds off further input.
// Configuration: cfg_write with cfg_index 0 sets iteration_count, index 1
// sets active_size; write only while the block is idle.
// Reset clears the control state and the registers to 2000 sweeps and size
// 50; the grid RAMs are not cleared. While the receiver stalls, the result
// waits in the output register and new writes are still accepted.
module jacobi_poisson_grid_solver import jpgs_pkg::*; #(
	parameter int GRID_SIDE = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [COORD_W-1:0]       row,
	input  logic [COORD_W-1:0]       column,
	input  logic signed [DATA_W-1:0] cell_value,
	input  logic signed [DATA_W-1:0] cell_source,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     kind,
	output logic signed [DATA_W-1:0] potential
);

	`include "jacobi_poisson_grid_solver_macros.svh"

	localparam int IDX_W = $clog2(GRID_SIDE);
	localparam int N_W = $clog2(GRID_SIDE + 1);
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(CELLS);

	// Stencil phases: phase k (N to E) issues one neighbor read, its data lands in k+1.
	localparam logic [2:0] PH_N = 3'd0;
	localparam logic [2:0] PH_S = 3'd1;
	localparam logic [2:0] PH_W = 3'd2;
	localparam logic [2:0] PH_E = 3'd3;
	localparam logic [2:0] PH_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CELL,
		ST_COPY,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [2:0]          phase_q;
	logic [IDX_W-1:0]    i_q;
	logic [IDX_W-1:0]    j_q;
	logic [N_W-1:0]      n_q;
	logic [ITER_W-1:0]   iters_q;
	logic [ITER_W-1:0]   sweep_q;
	logic [ITER_W-1:0]   iter_q;
	logic [SIZE_W-1:0]   size_q;
	logic                inside_q;
	logic                out_valid_q;
	logic                kind_q;
	logic [DATA_W-1:0]   potential_q;

	logic                accept;
	logic                host_in;
	logic [ADDR_W-1:0]   host_addr;
	logic [ADDR_W-1:0]   c_addr;
	logic [N_W-1:0]      n_sat;
	logic [N_W-1:0]      last_idx;
	logic                j_last;
	logic                i_last;
	logic                slot_free;

	logic                pot_we;
	logic [ADDR_W-1:0]   pot_waddr;
	logic [DATA_W-1:0]   pot_wdata;
	logic                pot_re;
	logic [ADDR_W-1:0]   pot_raddr;
	logic [DATA_W-1:0]   pot_rd;
	logic                src_we;
	logic                src_re;
	logic [DATA_W-1:0]   src_rd;
	logic                nxt_we;
	logic                nxt_re;
	logic [DATA_W-1:0]   nxt_rd;
	logic [DATA_W-1:0]   stn_result;
	stn_ctrl_t           stn_ctrl;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign potential = potential_q;
	assign slot_free = !out_valid_q || out_ready;

	assign host_in = (32'(row) < GRID_SIDE) && (32'(column) < GRID_SIDE);
	assign host_addr = ADDR_W'(row) * ADDR_W'(GRID_SIDE) + ADDR_W'(column);
	assign c_addr = ADDR_W'(i_q) * ADDR_W'(GRID_SIDE) + ADDR_W'(j_q);

	assign n_sat = (32'(size_q) > GRID_SIDE) ? N_W'(GRID_SIDE) : N_W'(size_q);
	assign last_idx = n_q - N_W'(2);
	assign j_last = (N_W'(j_q) == last_idx);
	assign i_last = (N_W'(i_q) == last_idx);

	// Read and write port steering for the three grid RAMs.
	always_comb begin
		pot_re = 1'b0;
		pot_raddr = c_addr;
		if (accept && command == CMD_READ && host_in) begin
			pot_re = 1'b1;
			pot_raddr = host_addr;
		end else if (state_q == ST_CELL) begin
			case (phase_q)
				PH_N: begin
					pot_re = 1'b1;
					pot_raddr = c_addr - ADDR_W'(GRID_SIDE);
				end
				PH_S: begin
					pot_re = 1'b1;
					pot_raddr = c_addr + ADDR_W'(GRID_SIDE);
				end
				PH_W: begin
					pot_re = 1'b1;
					pot_raddr = c_addr - ADDR_W'(1);
				end
				PH_E: begin
					pot_re = 1'b1;
					pot_raddr = c_addr + ADDR_W'(1);
				end
				default: pot_re = 1'b0;
			endcase
		end
	end

	always_comb begin
		pot_we = 1'b0;
		pot_waddr = host_addr;
		pot_wdata = cell_value;
		if (accept && command == CMD_WRITE && host_in) begin
			pot_we = 1'b1;
		end else if (state_q == ST_COPY && phase_q != PH_N) begin
			pot_we = 1'b1;
			pot_waddr = c_addr;
			pot_wdata = nxt_rd;
		end
	end

	assign src_we = accept && command == CMD_WRITE && host_in;
	assign src_re = (state_q == ST_CELL) && (phase_q == PH_N);
	assign nxt_we = (state_q == ST_CELL) && (phase_q == PH_LAST);
	assign nxt_re = (state_q == ST_COPY) && (phase_q == PH_N);

	assign stn_ctrl.load = (state_q == ST_CELL) && (phase_q == PH_S);
	assign stn_ctrl.add = (state_q == ST_CELL) && (phase_q == PH_W || phase_q == PH_E);

	jpgs_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_pot_ram (
		.clk   (clk),
		.we    (pot_we),
		.waddr (pot_waddr),
		.wdata (pot_wdata),
		.re    (pot_re),
		.raddr (pot_raddr),
		.rdata (pot_rd)
	);

	jpgs_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (host_addr),
		.wdata (cell_source),
		.re    (src_re),
		.raddr (c_addr),
		.rdata (src_rd)
	);

	jpgs_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (c_addr),
		.wdata (stn_result),
		.re    (nxt_re),
		.raddr (c_addr),
		.rdata (nxt_rd)
	);

	jpgs_stencil u_stencil (
		.clk    (clk),
		.ctrl   (stn_ctrl),
		.pot_in (pot_rd),
		.src_in (src_rd),
		.result (stn_result)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= ITER_RESET;
			size_q <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ITER: iter_q <= cfg_data;
				REG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: host commands, stencil sweep, copy-back and the result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_N;
			i_q <= IDX_W'(1);
			j_q <= IDX_W'(1);
			n_q <= '0;
			iters_q <= '0;
			sweep_q <= '0;
			inside_q <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q <= KIND_READ;
			potential_q <= '0;
		end else begin
			// The states that load the result slot refill it themselves.
			if (out_valid_q && out_ready && state_q != ST_READ && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_READ) begin
						inside_q <= host_in;
						state_q <= ST_READ;
					end else if (accept && command == CMD_SOLVE) begin
						n_q <= n_sat;
						iters_q <= iter_q;
						sweep_q <= '0;
						i_q <= IDX_W'(1);
						j_q <= IDX_W'(1);
						phase_q <= PH_N;
						if (iter_q == '0 || 32'(n_sat) < 3) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CELL;
						end
					end
				end
				ST_READ: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q <= KIND_READ;
						potential_q <= inside_q ? pot_rd : '0;
						state_q <= ST_IDLE;
					end
				end
				ST_CELL: begin
					if (phase_q == PH_LAST) begin
						phase_q <= PH_N;
						if (j_last) begin
							j_q <= IDX_W'(1);
							if (i_last) begin
								i_q <= IDX_W'(1);
								state_q <= ST_COPY;
							end else begin
								i_q <= i_q + IDX_W'(1);
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_COPY: begin
					if (phase_q == PH_N) begin
						phase_q <= PH_S;
					end else begin
						phase_q <= PH_N;
						if (j_last) begin
							j_q <= IDX_W'(1);
							if (i_last) begin
								i_q <= IDX_W'(1);
								sweep_q <= sweep_q + ITER_W'(1);
								if (sweep_q + ITER_W'(1) == iters_q) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_CELL;
								end
							end else begin
								i_q <= i_q + IDX_W'(1);
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q <= KIND_DONE;
						potential_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A sweep in progress never runs past the latched sweep count.
	`JPGS_ASSERT_IMP(a_sweep_bound, (state_q == ST_CELL || state_q == ST_COPY), (sweep_q < iters_q))
	// The potential RAM is never written while neighbors are being gathered.
	`JPGS_ASSERT_IMP(a_no_pot_write_in_cell, (state_q == ST_CELL), (!pot_we))
	// Stencil cells stay off the fixed edge ring.
	`JPGS_ASSERT_IMP(a_interior, (state_q == ST_CELL), (i_q != '0 && j_q != '0 && !(N_W'(i_q) > last_idx) && !(N_W'(j_q) > last_idx)))
	// The phase returns to N after the last phase, where the stencil result is stored.
	`JPGS_ASSERT_NXT(a_phase_wrap, (state_q == ST_CELL && phase_q == PH_LAST), (phase_q == PH_N))

endmodule

### design/jpgs_ram.sv
module jpgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/jpgs_stencil.sv
module jpgs_stencil import jpgs_pkg::*; (
	input  logic                     clk,
	input  stn_ctrl_t                ctrl,
	input  logic signed [DATA_W-1:0] pot_in,
	input  logic signed [DATA_W-1:0] src_in,
	output logic signed [DATA_W-1:0] result
);

	localparam int Q_W = SUM_W - 2;

	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sum;
	logic signed [Q_W-1:0]   quot;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= SUM_W'(pot_in) - SUM_W'(src_in);
		end else if (ctrl.add) begin
			acc_q <= acc_q + SUM_W'(pot_in);
		end
	end

	// The shift by two floors the quotient; then clamp to 32 bits.
	always_comb begin
		sum = acc_q + SUM_W'(pot_in);
		quot = sum[SUM_W-1:2];
		if (quot > Q_W'(32'sh7fffffff)) begin
			result = 32'sh7fffffff;
		end else if (quot < Q_W'(-33'sh80000000)) begin
			result = 32'sh80000000;
		end else begin
			result = quot[DATA_W-1:0];
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

// Self-checking testbench for the Jacobi Poisson grid solver.
// The stimulus tasks drive cell writes, reads and solve commands through the
// input channel. Every accepted transfer is applied to a behavioral copy of
// the grid, which yields the expected read data and done results. A checker
// process compares each output transfer against the oldest expectation.
module testbench;
	import jpgs_pkg::*;

	localparam int SIDE = 64;
	localparam int CELL_COUNT = SIDE * SIDE;
	// The unused command code; the block drops it without a result.
	localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
	// Solve lengths dominate the run. The longest is one solve of 65535 sweeps
	// on a 3x3 grid, so this limit leaves wide margin.
	localparam longint CYCLE_LIMIT = 10_000_000;

	typedef struct {
		logic             kind;
		logic [DATA_W-1:0] potential;
	} grid_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CMD_W-1:0]         command = CMD_WRITE;
	logic [COORD_W-1:0]       row = '0;
	logic [COORD_W-1:0]       column = '0;
	logic signed [DATA_W-1:0] cell_value = '0;
	logic signed [DATA_W-1:0] cell_source = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     kind;
	logic signed [DATA_W-1:0] potential;

	jacobi_poisson_grid_solver #(.GRID_SIDE(SIDE)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .row(row), .column(column),
		.cell_value(cell_value), .cell_source(cell_source),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .potential(potential)
	);

	always #5 clk = ~clk;

	// Behavioral copy of the block's state.
	logic signed [DATA_W-1:0] grid_pot [CELL_COUNT];
	logic signed [DATA_W-1:0] grid_src [CELL_COUNT];
	logic signed [DATA_W-1:0] grid_next [CELL_COUNT];
	bit                       cell_written [CELL_COUNT];
	int unsigned              written_cells [$];
	logic [ITER_W-1:0]        sweeps_per_solve = ITER_RESET;
	logic [SIZE_W-1:0]        side_len = SIZE_RESET;

	grid_result_t pending_results [$];
	int           fail_count = 0;
	int           items_sent = 0;
	bit           quiet = 1'b0;
	longint       cycle_count = 0;

	// Floor of the five-term sum over four, saturated to 32 bits.
	function automatic logic signed [DATA_W-1:0] relax_cell(input int unsigned c);
		longint s;
		longint q;
		s = longint'(grid_pot[c + SIDE]) + longint'(grid_pot[c - SIDE])
			+ longint'(grid_pot[c + 1]) + longint'(grid_pot[c - 1])
			- longint'(grid_src[c]);
		q = s >>> 2;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[DATA_W-1:0];
	endfunction

	function automatic void run_sweeps();
		int n;
		n = (side_len > SIDE) ? SIDE : int'(side_len);
		if (n < 3)
			return;
		for (int k = 0; k < int'(sweeps_per_solve); k++) begin
			for (int i = 1; i + 1 < n; i++)
				for (int j = 1; j + 1 < n; j++)
					grid_next[i*SIDE + j] = relax_cell(i*SIDE + j);
			for (int i = 1; i + 1 < n; i++)
				for (int j = 1; j + 1 < n; j++)
					grid_pot[i*SIDE + j] = grid_next[i*SIDE + j];
		end
	endfunction

	// Applies one accepted command to the copy and queues what it should return.
	function automatic void apply_command(input logic [CMD_W-1:0] cmd,
			input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
			input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] s);
		int unsigned a;
		grid_result_t res;
		a = r * SIDE + c;
		case (cmd)
			CMD_WRITE: begin
				grid_pot[a] = v;
				grid_src[a] = s;
				if (!cell_written[a]) begin
					cell_written[a] = 1'b1;
					written_cells.push_back(a);
				end
			end
			CMD_SOLVE: begin
				run_sweeps();
				res.kind = KIND_DONE;
				res.potential = '0;
				pending_results.push_back(res);
			end
			CMD_READ: begin
				res.kind = KIND_READ;
				res.potential = grid_pot[a];
				pending_results.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// Drives one command and holds it until the transfer, with random idle
	// cycles ahead of it. Valid only drops when a gap is taken.
	task automatic send_command(input logic [CMD_W-1:0] cmd,
			input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
			input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] s);
		if (!quiet && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		row <= r;
		column <= c;
		cell_value <= v;
		cell_source <= s;
		do
			@(posedge clk);
		while (!in_ready);
		apply_command(cmd, r, c, v, s);
		items_sent++;
	endtask

	// Mixes full-range values with small ones so both saturation and ordinary
	// relaxation are seen.
	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(1) == 0)
			return $urandom;
		return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
	endfunction

	task automatic write_cell(input int r, input int c);
		send_command(CMD_WRITE, COORD_W'(r), COORD_W'(c), pick_value(), pick_value());
	endtask

	// Lowers valid and waits for every queued result, then lets the block settle
	// in case its last command was a write.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_ITER)
			sweeps_per_solve = data;
		else
			side_len = data[SIZE_W-1:0];
	endtask

	// Solve reads every cell of the active square but its corners, so each one is written first.
	task automatic fill_square();
		int n;
		n = (side_len > SIDE) ? SIDE : int'(side_len);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (!cell_written[r*SIDE + c])
					write_cell(r, c);
	endtask

	task automatic read_random_cell();
		int unsigned a;
		a = written_cells[$urandom_range(written_cells.size() - 1)];
		send_command(CMD_READ, COORD_W'(a / SIDE), COORD_W'(a % SIDE), $urandom, $urandom);
	endtask

	task automatic test_directed();
		logic [DATA_W-1:0] extremes [4];
		extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
		write_register(REG_ITER, 16'd1);
		write_register(REG_SIZE, 16'd3);
		// Ring at the positive limit and a negative source drive the center
		// into positive saturation.
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_command(CMD_WRITE, COORD_W'(r), COORD_W'(c), extremes[0], extremes[1]);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		send_command(CMD_READ, 1, 1, '0, '0);
		// Now the negative limit with a positive source.
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_command(CMD_WRITE, COORD_W'(r), COORD_W'(c), extremes[1], extremes[0]);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		send_command(CMD_READ, 1, 1, '0, '0);
		send_command(CMD_READ, 0, 2, '0, '0);
		// A cell outside the active square keeps its value through a solve.
		send_command(CMD_WRITE, 63, 63, extremes[3], extremes[2]);
		send_command(CMD_IGNORED, 63, 63, extremes[0], extremes[0]);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		send_command(CMD_READ, 63, 63, '0, '0);
		send_command(CMD_READ, 1, 1, '0, '0);
	endtask

	task automatic test_register_extremes();
		// No interior cells at sizes below three, even with the longest solve.
		write_register(REG_SIZE, 16'hFF80);
		write_register(REG_ITER, 16'hFFFF);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		write_register(REG_SIZE, 16'd2);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		// Zero sweeps leave the grid alone.
		write_register(REG_ITER, 16'd0);
		write_register(REG_SIZE, 16'd5);
		fill_square();
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		read_random_cell();
		// The longest sweep count on the smallest grid with an interior.
		write_register(REG_ITER, 16'hFFFF);
		write_register(REG_SIZE, 16'd3);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		send_command(CMD_READ, 1, 1, '0, '0);
		// Sizes past the store clamp to the full grid.
		write_register(REG_ITER, 16'd1);
		write_register(REG_SIZE, 16'h007F);
		fill_square();
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		send_command(CMD_READ, 32, 17, '0, '0);
		send_command(CMD_READ, 62, 62, '0, '0);
		write_register(REG_SIZE, 16'd64);
		send_command(CMD_SOLVE, 0, 0, '0, '0);
		send_command(CMD_READ, 1, 62, '0, '0);
	endtask

	task automatic test_random_traffic();
		int n;
		int pick;
		int start_count;
		start_count = items_sent;
		while (items_sent - start_count < 700) begin
			write_register(REG_ITER, ITER_W'($urandom_range(1, 4)));
			write_register(REG_SIZE,
				{9'($urandom_range(0, 511)), 7'($urandom_range(3, 8))});
			n = int'(side_len);
			fill_square();
			// A stretch with no idling on either side now and then.
			quiet = ($urandom_range(5) == 0);
			repeat (40) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					if ($urandom_range(9) < 7)
						write_cell($urandom_range(n - 1), $urandom_range(n - 1));
					else
						write_cell($urandom_range(63), $urandom_range(63));
				end else if (pick < 80)
					read_random_cell();
				else if (pick < 90)
					send_command(CMD_SOLVE, COORD_W'($urandom), COORD_W'($urandom),
						$urandom, $urandom);
				else
					send_command(CMD_IGNORED, COORD_W'($urandom), COORD_W'($urandom),
						$urandom, $urandom);
			end
			quiet = 1'b0;
		end
	endtask

	// Receiver side: stall about a quarter of the cycles unless in a quiet stretch.
	always @(posedge clk)
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);

	// Each output transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		grid_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation: kind %0d potential %0h", kind, potential);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind expected %0d actual %0d", want.kind, kind);
					fail_count++;
				end
				if (potential !== want.potential) begin
					$error("potential expected %0h actual %0h", want.potential, potential);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/jpgs_pkg.sv
design/jpgs_ram.sv
design/jpgs_stencil.sv
design/jacobi_poisson_grid_solver.sv
test/testbench.sv
